// ===== rtl/wpmh_pkg.sv =====
// shared types, constants and modular arithmetic helpers for the word polynomial hash
`timescale 1ns / 1ps

package wpmh_pkg;

   localparam logic [29:0] MODULUS    = 30'd1001145147;
   localparam logic [6:0]  MULTIPLIER = 7'd114;
   // floor(114 * 2^38 / MODULUS), quotient estimate from the top 16 hash bits
   localparam logic [14:0] QUOT_K     = 15'd31300;
   localparam logic [32:0] MOD_W      = 33'(MODULUS);
   localparam logic [30:0] NEG_ONE    = '1;

   typedef struct packed {
      logic [29:0] hash;
      logic [31:0] pad_word;
      logic        has_pad;
      logic        empty;
   } fin_type;

   function automatic logic [36:0] mul_base(input logic [29:0] h);
      return 37'(h) * 37'(MULTIPLIER);
   endfunction

   // never above the true quotient of h*114/MODULUS, at most one below
   function automatic logic [6:0] quot_est(input logic [29:0] h);
      logic [30:0] t;
      t = 31'(h[29:14]) * 31'(QUOT_K);
      return t[30:24];
   endfunction

   // result stays below twice the modulus
   function automatic logic [30:0] part_reduce(input logic [36:0] p, input logic [6:0] q);
      logic [36:0] t;
      t = p - 37'(q) * 37'(MODULUS);
      return t[30:0];
   endfunction

   // (r + w) mod MODULUS for r below twice the modulus
   function automatic logic [29:0] add_mod(input logic [30:0] r, input logic [31:0] w);
      logic [32:0] s;
      logic [32:0] d;
      s = 33'(r) + 33'(w);
      if (s >= 33'd6 * MOD_W) begin
         d = s - 33'd6 * MOD_W;
      end else if (s >= 33'd5 * MOD_W) begin
         d = s - 33'd5 * MOD_W;
      end else if (s >= 33'd4 * MOD_W) begin
         d = s - 33'd4 * MOD_W;
      end else if (s >= 33'd3 * MOD_W) begin
         d = s - 33'd3 * MOD_W;
      end else if (s >= 33'd2 * MOD_W) begin
         d = s - 33'd2 * MOD_W;
      end else if (s >= MOD_W) begin
         d = s - MOD_W;
      end else begin
         d = s;
      end
      return d[29:0];
   endfunction

endpackage

// ===== rtl/wpmh_state.sv =====
// byte packing and running hash state with the precomputed base product
`timescale 1ns / 1ps

module wpmh_state (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  logic             last,
   input  logic [7:0]       data_byte,
   input  logic [15:0]      byte_offset,
   input  logic [15:0]      range_start,
   input  logic [15:0]      range_end,
   output wpmh_pkg::fin_type fin
);

   logic [29:0] hash_ff, hash_in;
   logic [23:0] word_ff, word_in;
   logic [1:0]  count_ff, count_in;
   logic [36:0] prod_ff;
   logic [6:0]  quot_ff;
   logic [30:0] part_ff;

   logic        in_rng;
   logic        full;
   logic [29:0] hash_upd;
   logic [23:0] word_upd;
   logic [1:0]  count_upd;
   logic [31:0] pad_word;

   assign in_rng = (byte_offset >= range_start) && (byte_offset < range_end);
   assign full   = in_rng && (count_ff == 2'd3);

   always_comb begin
      hash_upd  = hash_ff;
      word_upd  = word_ff;
      count_upd = count_ff;
      if (full) begin
         hash_upd  = wpmh_pkg::add_mod(part_ff, {word_ff, data_byte});
         word_upd  = '0;
         count_upd = '0;
      end else if (in_rng) begin
         word_upd  = {word_ff[15:0], data_byte};
         count_upd = count_ff + 2'd1;
      end
   end

   always_comb begin
      case (count_upd)
         2'd1:    pad_word = {word_upd[7:0], 24'd0};
         2'd2:    pad_word = {word_upd[15:0], 16'd0};
         2'd3:    pad_word = {word_upd[23:0], 8'd0};
         default: pad_word = '0;
      endcase
   end

   assign fin.hash     = hash_upd;
   assign fin.pad_word = pad_word;
   assign fin.has_pad  = (count_upd != 2'd0);
   assign fin.empty    = (range_start >= range_end);

   always_comb begin
      hash_in  = hash_ff;
      word_in  = word_ff;
      count_in = count_ff;
      if (fire) begin
         if (last) begin
            hash_in  = '0;
            word_in  = '0;
            count_in = '0;
         end else begin
            hash_in  = hash_upd;
            word_in  = word_upd;
            count_in = count_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff  <= '0;
         word_ff  <= '0;
         count_ff <= '0;
      end else begin
         hash_ff  <= hash_in;
         word_ff  <= word_in;
         count_ff <= count_in;
      end
   end

   // hash*114 reduced through prod_ff/quot_ff into part_ff, behind the hash register
   always_ff @(posedge clock) begin
      prod_ff <= wpmh_pkg::mul_base(hash_ff);
      quot_ff <= wpmh_pkg::quot_est(hash_ff);
      part_ff <= wpmh_pkg::part_reduce(prod_ff, quot_ff);
   end

endmodule

// ===== rtl/word_polynomial_mod_hash_top.sv =====
// word polynomial mod hash: input register, state update and final fold pipeline
// the result of a packet passes fold stage 1, fold stage 2 and the result register
// throughput: one byte per cycle unless a last byte waits on a full final fold;
//   words fold with hash*114 mod p from part_ff; final padded fold runs in 3 stages
// reset: synchronous, clears hash state and all valid flags
`timescale 1ns / 1ps

module word_polynomial_mod_hash_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_data_byte,
   input  logic [15:0]        req_byte_offset,
   input  logic [15:0]        req_range_start,
   input  logic [15:0]        req_range_end,
   input  logic               req_packet_last,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [30:0] rsp_hash_value
);

   // input beat register
   logic        in_v_ff, in_v_in;
   logic [7:0]  in_byte_ff;
   logic [15:0] in_off_ff;
   logic [15:0] in_start_ff;
   logic [15:0] in_end_ff;
   logic        in_last_ff;

   // final fold stage 1
   logic        f1_v_ff, f1_v_in;
   logic [36:0] f1_prod_ff;
   logic [6:0]  f1_quot_ff;
   logic [31:0] f1_word_ff;
   logic [29:0] f1_hash_ff;
   logic        f1_pad_ff;
   logic        f1_empty_ff;

   // final fold stage 2
   logic        f2_v_ff, f2_v_in;
   logic [30:0] f2_part_ff;
   logic [31:0] f2_word_ff;
   logic [29:0] f2_hash_ff;
   logic        f2_pad_ff;
   logic        f2_empty_ff;

   // result register
   logic        out_v_ff, out_v_in;
   logic [30:0] out_hash_ff;

   logic             accept;
   logic             in_fire;
   logic             f1_free;
   logic             f2_free;
   logic             f1_move;
   logic             out_load;
   wpmh_pkg::fin_type fin;

   wpmh_state u_state (
      .clock       (clock),
      .reset       (reset),
      .fire        (in_fire),
      .last        (in_last_ff),
      .data_byte   (in_byte_ff),
      .byte_offset (in_off_ff),
      .range_start (in_start_ff),
      .range_end   (in_end_ff),
      .fin         (fin)
   );

   assign out_load  = f2_v_ff && (!out_v_ff || rsp_ready);
   assign f2_free   = !f2_v_ff || out_load;
   assign f1_move   = f1_v_ff && f2_free;
   assign f1_free   = !f1_v_ff || f2_free;
   assign in_fire   = in_v_ff && (!in_last_ff || f1_free);
   assign req_ready = !in_v_ff || in_fire;
   assign accept    = req_valid && req_ready;

   assign in_v_in  = accept || (in_v_ff && !in_fire);
   assign f1_v_in  = (in_fire && in_last_ff) || (f1_v_ff && !f2_free);
   assign f2_v_in  = f1_move || (f2_v_ff && !out_load);
   assign out_v_in = out_load || (out_v_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff  <= 1'b0;
         f1_v_ff  <= 1'b0;
         f2_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         in_v_ff  <= in_v_in;
         f1_v_ff  <= f1_v_in;
         f2_v_ff  <= f2_v_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff  <= req_data_byte;
         in_off_ff   <= req_byte_offset;
         in_start_ff <= req_range_start;
         in_end_ff   <= req_range_end;
         in_last_ff  <= req_packet_last;
      end
      if (in_fire && in_last_ff) begin
         f1_prod_ff  <= wpmh_pkg::mul_base(fin.hash);
         f1_quot_ff  <= wpmh_pkg::quot_est(fin.hash);
         f1_word_ff  <= fin.pad_word;
         f1_hash_ff  <= fin.hash;
         f1_pad_ff   <= fin.has_pad;
         f1_empty_ff <= fin.empty;
      end
      if (f1_move) begin
         f2_part_ff  <= wpmh_pkg::part_reduce(f1_prod_ff, f1_quot_ff);
         f2_word_ff  <= f1_word_ff;
         f2_hash_ff  <= f1_hash_ff;
         f2_pad_ff   <= f1_pad_ff;
         f2_empty_ff <= f1_empty_ff;
      end
      if (out_load) begin
         if (f2_empty_ff) begin
            out_hash_ff <= wpmh_pkg::NEG_ONE;
         end else if (f2_pad_ff) begin
            out_hash_ff <= {1'b0, wpmh_pkg::add_mod(f2_part_ff, f2_word_ff)};
         end else begin
            out_hash_ff <= {1'b0, f2_hash_ff};
         end
      end
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_hash_value = out_hash_ff;

endmodule
